// ===== design/nearest_valid_cell_ring_search_macros.svh =====
// Assertion macros shared by the checker
`ifndef NEAREST_VALID_CELL_RING_SEARCH_MACROS_SVH
`define NEAREST_VALID_CELL_RING_SEARCH_MACROS_SVH
`define NVC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nvc check failed");
`define NVC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nvc check failed");
`endif

// ===== design/nvcrs_pkg.sv =====
// Package: constants and types of the ring search block
`default_nettype none
package nvcrs_pkg;
    localparam int DEF_MAX_COLS   = 256;
    localparam int DEF_MAX_ROWS   = 256;
    localparam int DEF_COORD_BITS = 24;
    localparam int CFG_W          = 9;
    localparam int IDX_W          = 8;
    localparam int POS_W          = 24;
    localparam logic [0:0] REG_GRID_COLS = 1'b0;
    localparam logic [0:0] REG_GRID_ROWS = 1'b1;
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic load_wr;
        logic org_rd;
        logic org_cap;
        logic ring_init;
        logic cell_rd;
        logic cell_eval;
        logic best_clr;
        logic res_load;
        logic res_take;
    } nvcrs_cmd_t;

    typedef struct packed {
        logic ring_last_cell;
        logic have_best;
        logic search_done;
        logic res_full;
    } nvcrs_sts_t;
endpackage
`default_nettype wire

// ===== design/nvcrs_if.sv =====
// Valid/ready channel interfaces for input and result words
`default_nettype none
interface nvcrs_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  col;
    logic [7:0]  row;
    logic        land;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic        pos_missing;
    modport source (output valid, kind, col, row, land, pos_x, pos_y, pos_missing,
                    input ready);
    modport sink   (input valid, kind, col, row, land, pos_x, pos_y, pos_missing,
                    output ready);
endinterface

interface nvcrs_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [7:0] near_col;
    logic [7:0] near_row;
    modport source (output valid, found, near_col, near_row, input ready);
    modport sink   (input valid, found, near_col, near_row, output ready);
endinterface
`default_nettype wire

// ===== design/nearest_valid_cell_ring_search.sv =====
// Top level of the nearest water cell ring search
`default_nettype none
// A load word writes one cell into the grid store and is taken while idle. A query
// word reads its origin, then visits every cell of each square ring of radius 1, 2
// and upward (store read, then compare, per cell), ring r holding 8r cells, stopping
// at the end of the first ring with a candidate water cell or of the ring whose radius
// reaches both grid sizes; the result register is then loaded once it is free. The
// single store port sets the pace. Cells never loaded must not be reached by a query.
module nearest_valid_cell_ring_search
    import nvcrs_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [0:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    nvcrs_in_if.sink              in_ch,
    nvcrs_out_if.source           out_ch
);
    nvcrs_cmd_t cmd;
    nvcrs_sts_t sts;

    nvcrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_kind   (in_ch.kind),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    nvcrs_dp #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_col         (in_ch.col),
        .in_row         (in_ch.row),
        .in_land        (in_ch.land),
        .in_pos_x       (in_ch.pos_x),
        .in_pos_y       (in_ch.pos_y),
        .in_pos_missing (in_ch.pos_missing),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_ch.valid),
        .out_found      (out_ch.found),
        .out_near_col   (out_ch.near_col),
        .out_near_row   (out_ch.near_row)
    );
endmodule
`default_nettype wire

// ===== design/nvcrs_ram.sv =====
// Generic single-port RAM with registered read
`default_nettype none
module nvcrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== design/nvcrs_ctrl.sv =====
// Controller state machine of the ring search
`default_nettype none
module nvcrs_ctrl
    import nvcrs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_kind,
    output logic            in_ready,
    input  wire logic       out_ready,
    output nvcrs_cmd_t      cmd,
    input  wire nvcrs_sts_t sts
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ORG   = 6'b000010,
        ST_INIT  = 6'b000100,
        ST_READ  = 6'b001000,
        ST_EVAL  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        cmd.res_take = sts.res_full && out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_kind == KIND_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.org_rd = 1'b1;
                        state_next = ST_ORG;
                    end
                end
            end
            ST_ORG:
            begin
                cmd.org_cap   = 1'b1;
                cmd.ring_init = 1'b1;
                cmd.best_clr  = 1'b1;
                state_next    = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.cell_rd = 1'b1;
                state_next  = ST_EVAL;
            end
            ST_READ:
            begin
                cmd.cell_rd = 1'b1;
                state_next  = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.cell_eval = 1'b1;
                if (sts.ring_last_cell && (sts.have_best || sts.search_done))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (!sts.res_full || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== design/nvcrs_dp.sv =====
// Datapath: grid store, ring walker, distance compare and result register
`default_nettype none
module nvcrs_dp
    import nvcrs_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [0:0]              cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic [IDX_W-1:0]        in_col,
    input  wire logic [IDX_W-1:0]        in_row,
    input  wire logic                    in_land,
    input  wire logic signed [POS_W-1:0] in_pos_x,
    input  wire logic signed [POS_W-1:0] in_pos_y,
    input  wire logic                    in_pos_missing,
    input  wire nvcrs_cmd_t              cmd,
    output nvcrs_sts_t                   sts,
    output logic                         out_valid,
    output logic                         out_found,
    output logic [IDX_W-1:0]             out_near_col,
    output logic [IDX_W-1:0]             out_near_row
);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = CW + RW;
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int MEMW  = 2 * COORD_BITS + 2;
    localparam int SW    = 14;
    localparam int DW    = COORD_BITS + 1;
    localparam int QW    = 2 * DW + 1;
    localparam logic [CFG_W-1:0] CFG_MAXC = CFG_W'(MAX_COLS > 511 ? 511 : MAX_COLS);
    localparam logic [CFG_W-1:0] CFG_MAXR = CFG_W'(MAX_ROWS > 511 ? 511 : MAX_ROWS);

    logic [CFG_W-1:0] gcols_reg, grows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gcols_reg <= CFG_W'(256) > CFG_MAXC ? CFG_MAXC : CFG_W'(256);
            grows_reg <= CFG_W'(256) > CFG_MAXR ? CFG_MAXR : CFG_W'(256);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_GRID_COLS)
            begin
                gcols_reg <= cfg_data > CFG_MAXC ? CFG_MAXC : cfg_data;
            end
            else
            begin
                grows_reg <= cfg_data > CFG_MAXR ? CFG_MAXR : cfg_data;
            end
        end
    end

    // ring walker: side 0 left, 1 bottom, 2 right, 3 top
    logic signed [SW-1:0] oc_reg, or_reg, lv_reg, i_reg, cc_reg, cr_reg;
    logic [1:0]           side_reg;
    logic signed [SW-1:0] pc_next, pr_next, i_next;
    logic [1:0]           side_next;
    logic                 last_cell;

    logic                 ld_ok, org_in;
    logic [AW-1:0]        addr;
    logic                 mem_we;
    logic [MEMW-1:0]      wdata, rdata;
    logic                 org_in_reg;

    assign ld_ok  = (32'(in_col) < MAX_COLS) && (32'(in_row) < MAX_ROWS);
    assign mem_we = cmd.load_wr && ld_ok;
    assign wdata  = {in_land, in_pos_missing,
                     COORD_BITS'(in_pos_x), COORD_BITS'(in_pos_y)};

    always_comb
    begin
        if (cmd.cell_rd)
        begin
            addr = {cr_reg[RW-1:0], cc_reg[CW-1:0]};
        end
        else
        begin
            addr = {RW'(in_row), CW'(in_col)};
        end
    end

    nvcrs_ram #(.WIDTH(MEMW), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    logic                         r_land, r_miss;
    logic signed [COORD_BITS-1:0] r_x, r_y;
    assign r_land = rdata[MEMW-1];
    assign r_miss = rdata[MEMW-2];
    assign r_x    = rdata[2*COORD_BITS-1:COORD_BITS];
    assign r_y    = rdata[COORD_BITS-1:0];

    logic signed [COORD_BITS-1:0] ox_reg, oy_reg;
    logic                         omiss_reg;

    always_comb
    begin
        side_next = side_reg;
        i_next    = i_reg + SW'(1);
        last_cell = 1'b0;
        if (i_reg == lv_reg)
        begin
            i_next    = -lv_reg + SW'(1);
            side_next = side_reg + 2'd1;
            last_cell = (side_reg == 2'd3);
        end
        unique case (side_next)
            2'd0: begin pc_next = oc_reg - lv_reg; pr_next = or_reg + i_next; end
            2'd1: begin pc_next = oc_reg + i_next; pr_next = or_reg - lv_reg; end
            2'd2: begin pc_next = oc_reg + lv_reg; pr_next = or_reg + i_next; end
            default: begin pc_next = oc_reg + i_next; pr_next = or_reg + lv_reg; end
        endcase
    end

    logic signed [SW-1:0] lv_inc;
    assign lv_inc = lv_reg + SW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oc_reg <= '0; or_reg <= '0; lv_reg <= '0; i_reg <= '0;
            cc_reg <= '0; cr_reg <= '0; side_reg <= '0; org_in_reg <= 1'b0;
        end
        else
        begin
            if (cmd.org_rd)
            begin
                oc_reg     <= SW'(in_col);
                or_reg     <= SW'(in_row);
                org_in_reg <= ld_ok;
            end
            if (cmd.ring_init)
            begin
                lv_reg   <= SW'(1);
                side_reg <= 2'd0;
                i_reg    <= -SW'(1);
                cc_reg   <= oc_reg - SW'(1);
                cr_reg   <= or_reg - SW'(1);
            end
            else if (cmd.cell_eval)
            begin
                if (last_cell)
                begin
                    lv_reg   <= lv_inc;
                    side_reg <= 2'd0;
                    i_reg    <= -lv_inc;
                    cc_reg   <= oc_reg - lv_inc;
                    cr_reg   <= or_reg - lv_inc;
                end
                else
                begin
                    side_reg <= side_next;
                    i_reg    <= i_next;
                    cc_reg   <= pc_next;
                    cr_reg   <= pr_next;
                end
            end
        end
    end

    assign org_in = org_in_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.org_cap)
        begin
            ox_reg    <= org_in ? r_x : '0;
            oy_reg    <= org_in ? r_y : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            omiss_reg <= 1'b1;
        end
        else if (cmd.org_cap)
        begin
            omiss_reg <= org_in ? r_miss : 1'b1;
        end
    end

    // candidate distance
    logic                 on_grid, cand;
    logic signed [DW-1:0] dx, dy;
    logic [DW-1:0]        adx, ady;
    logic [QW-1:0]        cand_dist;

    assign on_grid = !cc_reg[SW-1] && !cr_reg[SW-1]
                     && (cc_reg < $signed({1'b0, SW'(gcols_reg)}))
                     && (cr_reg < $signed({1'b0, SW'(grows_reg)}));
    assign cand = on_grid && !r_land && (omiss_reg || !r_miss);

    always_comb
    begin
        if (omiss_reg)
        begin
            dx = DW'(oc_reg - cc_reg);
            dy = DW'(or_reg - cr_reg);
        end
        else
        begin
            dx = DW'(ox_reg) - DW'(r_x);
            dy = DW'(oy_reg) - DW'(r_y);
        end
        adx       = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ady       = dy[DW-1] ? DW'(-dy) : DW'(dy);
        cand_dist = QW'(adx * adx) + QW'(ady * ady);
    end

    logic          hb_reg;
    logic [QW-1:0] bd_reg;
    logic [IDX_W-1:0] bc_reg, br_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_reg <= 1'b0;
        end
        else if (cmd.best_clr)
        begin
            hb_reg <= 1'b0;
        end
        else if (cmd.cell_eval && cand)
        begin
            hb_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cell_eval && cand && (!hb_reg || cand_dist < bd_reg))
        begin
            bd_reg <= cand_dist;
            bc_reg <= IDX_W'(cc_reg);
            br_reg <= IDX_W'(cr_reg);
        end
    end

    logic hb_now, done_now;
    assign hb_now   = hb_reg || cand;
    assign done_now = !((lv_inc <= $signed({1'b0, SW'(gcols_reg)}))
                        || (lv_inc <= $signed({1'b0, SW'(grows_reg)})));

    assign sts.ring_last_cell = last_cell;
    assign sts.have_best      = hb_now;
    assign sts.search_done    = done_now;
    assign sts.res_full       = out_valid;

    // output register
    logic ov_reg;
    logic f_reg;
    logic [IDX_W-1:0] nc_reg, nr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            ov_reg <= 1'b1;
        end
        else if (cmd.res_take)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            f_reg  <= hb_reg;
            nc_reg <= hb_reg ? bc_reg : '0;
            nr_reg <= hb_reg ? br_reg : '0;
        end
    end

    assign out_valid    = ov_reg;
    assign out_found    = f_reg;
    assign out_near_col = nc_reg;
    assign out_near_row = nr_reg;
endmodule
`default_nettype wire

// ===== design/nvcrs_checker.sv =====
// Port checker of the ring search, bound to the top level
`default_nettype none
`include "nearest_valid_cell_ring_search_macros.svh"
module nvcrs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       in_kind,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       out_found,
    input wire logic [7:0] out_near_col,
    input wire logic [7:0] out_near_row
);
    `NVC_ASSERT_IMPL(a_notfound_zero, out_valid && !out_found,
        out_near_col == 8'd0 && out_near_row == 8'd0)
    `NVC_ASSERT_NEXT(a_query_busy, in_valid && in_ready && in_kind, !in_ready)
    `NVC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_found))
    `NVC_ASSERT_NEXT(a_load_quiet, in_valid && in_ready && !in_kind && !out_valid,
        !out_valid)
endmodule

bind nearest_valid_cell_ring_search nvcrs_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_kind      (in_ch.kind),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_found    (out_ch.found),
    .out_near_col (out_ch.near_col),
    .out_near_row (out_ch.near_row)
);
`default_nettype wire
